// ----- rtl/bzlk_pkg.sv -----
// ----------------------------------------------------------------------------
// Bezier easing lookup package
// Shared widths, codes and constants for the easing table lookup unit.
// ----------------------------------------------------------------------------
package bzlk_pkg;

	// Default table size limit
	localparam int DEF_MAX_SPAN = 256;

	// Field widths
	localparam int CoordW = 8;
	localparam int SpanW  = 9;
	localparam int CfgW   = 9;
	localparam int IdxW   = 3;
	localparam int Q16W   = 17;

	// Curve constants
	localparam int MinSpan   = 16;
	localparam int EndCoord  = 127;
	localparam int FracBits  = 16;
	// Quotient never reaches 8.0 (at most 3*255/127 of full scale)
	localparam int QuotBits  = FracBits + 3;
	localparam logic [Q16W-1:0] Q16Max = '1;

	// Register index codes
	localparam logic [IdxW-1:0] REG_CTRL0_X   = 3'd0;
	localparam logic [IdxW-1:0] REG_CTRL0_Y   = 3'd1;
	localparam logic [IdxW-1:0] REG_CTRL1_X   = 3'd2;
	localparam logic [IdxW-1:0] REG_CTRL1_Y   = 3'd3;
	localparam logic [IdxW-1:0] REG_SPAN      = 3'd4;

	// Register reset values
	localparam logic [CoordW-1:0] RST_CTRL0 = 8'd20;
	localparam logic [CoordW-1:0] RST_CTRL1 = 8'd107;
	localparam logic [SpanW-1:0]  RST_SPAN  = 9'd16;

endpackage

// ----- rtl/bezier_easing_table_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// Bezier easing table lookup unit
// Samples a cubic Bezier easing curve into a table after each write to a
// known register and answers each position with the y of the nearest sampled x.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  input    | in_valid / in_stall    | position  (17 b, Q16)
//  output   | out_valid / out_stall  | eased     (17 b, Q16)
//  config   | cfg_we                 | cfg_idx (3 b), cfg_wdata (9 b)
//
// A query scans the N+1 table entries (N = effective span, 16..MAX_SPAN)
// through one memory read port, one entry per cycle, then passes the
// registered read and the output register.
// Each write to a known register refills the table: 2*(N+1) items enter the
// coordinate pipeline (4 arithmetic stages and a row of 19 divider cells);
// in_stall stays high until the last item has left it.
// Reset clears control only; the table holds no data until the first write.
// A finished result waits in the output register while the next item is
// taken; a scan that ends while that register is still held waits for it.
// ----------------------------------------------------------------------------
module bezier_easing_table_lookup_unit #(
	parameter int MAX_SPAN = bzlk_pkg::DEF_MAX_SPAN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bzlk_pkg::IdxW-1:0]     cfg_idx,
	input  logic [bzlk_pkg::CfgW-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bzlk_pkg::Q16W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bzlk_pkg::Q16W-1:0]     eased
);

	localparam int SW    = $clog2(MAX_SPAN + 1);
	localparam int Depth = MAX_SPAN + 1;
	localparam int CW    = bzlk_pkg::CoordW;
	localparam int QW    = bzlk_pkg::Q16W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	// Configuration registers
	logic [CW-1:0]                ctrl0_x_q, ctrl0_y_q, ctrl1_x_q, ctrl1_y_q;
	logic [bzlk_pkg::SpanW-1:0]   span_q;
	logic [SW-1:0]                n_eff;
	logic                         cfg_hit;

	// Fill sequencer
	logic          filling_q;
	logic [SW-1:0] fill_i_q;
	logic          fill_sel_q;
	logic          pipe_busy;
	logic          busy;

	// Coordinate pipeline results
	logic          wr_valid;
	logic [SW-1:0] wr_idx;
	logic          wr_sel;
	logic [QW-1:0] wr_coord;

	// Sample tables
	logic [QW-1:0] sample_x [Depth];
	logic [QW-1:0] sample_y [Depth];
	logic [QW-1:0] rx_q, ry_q;

	// Scan control
	state_t        state_q;
	logic [QW-1:0] pos_q;
	logic          issuing_q;
	logic [SW-1:0] rd_addr_q;
	logic          cmp_v_s1;
	logic          cmp_last_s1;
	logic [SW-1:0] cmp_idx_s1;
	logic [QW-1:0] best_d_q, best_y_q;
	logic [QW-1:0] cur_d;
	logic          take;
	logic [QW-1:0] nb_y;
	logic          scan_done;
	logic          out_free;
	logic          load_out;
	logic          in_acc;

	// Effective span, clamped to the table range
	always_comb begin
		if (span_q < bzlk_pkg::SpanW'(bzlk_pkg::MinSpan)) begin
			n_eff = SW'(bzlk_pkg::MinSpan);
		end else if (32'(span_q) > MAX_SPAN) begin
			n_eff = SW'(MAX_SPAN);
		end else begin
			n_eff = SW'(span_q);
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl0_x_q <= bzlk_pkg::RST_CTRL0;
			ctrl0_y_q <= bzlk_pkg::RST_CTRL0;
			ctrl1_x_q <= bzlk_pkg::RST_CTRL1;
			ctrl1_y_q <= bzlk_pkg::RST_CTRL1;
			span_q    <= bzlk_pkg::RST_SPAN;
		end else if (cfg_we) begin
			case (cfg_idx)
				bzlk_pkg::REG_CTRL0_X: ctrl0_x_q <= cfg_wdata[CW-1:0];
				bzlk_pkg::REG_CTRL0_Y: ctrl0_y_q <= cfg_wdata[CW-1:0];
				bzlk_pkg::REG_CTRL1_X: ctrl1_x_q <= cfg_wdata[CW-1:0];
				bzlk_pkg::REG_CTRL1_Y: ctrl1_y_q <= cfg_wdata[CW-1:0];
				bzlk_pkg::REG_SPAN:    span_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg_hit = cfg_we && (cfg_idx == bzlk_pkg::REG_CTRL0_X ||
	                            cfg_idx == bzlk_pkg::REG_CTRL0_Y ||
	                            cfg_idx == bzlk_pkg::REG_CTRL1_X ||
	                            cfg_idx == bzlk_pkg::REG_CTRL1_Y ||
	                            cfg_idx == bzlk_pkg::REG_SPAN);

	// Issue x then y for each sample index; restart on every known write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filling_q  <= 1'b0;
			fill_i_q   <= '0;
			fill_sel_q <= 1'b0;
		end else if (cfg_hit) begin
			filling_q  <= 1'b1;
			fill_i_q   <= '0;
			fill_sel_q <= 1'b0;
		end else if (filling_q) begin
			fill_sel_q <= ~fill_sel_q;
			if (fill_sel_q) begin
				if (fill_i_q == n_eff) begin
					filling_q <= 1'b0;
				end else begin
					fill_i_q <= fill_i_q + 1'b1;
				end
			end
		end
	end

	bzlk_coord #(
		.MAX_SPAN(MAX_SPAN),
		.SW      (SW)
	) u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (filling_q),
		.in_i     (fill_i_q),
		.in_n     (n_eff),
		.in_sel   (fill_sel_q),
		.in_c0    (fill_sel_q ? ctrl0_y_q : ctrl0_x_q),
		.in_c1    (fill_sel_q ? ctrl1_y_q : ctrl1_x_q),
		.out_valid(wr_valid),
		.out_idx  (wr_idx),
		.out_sel  (wr_sel),
		.out_coord(wr_coord),
		.busy     (pipe_busy)
	);

	assign busy = filling_q | pipe_busy;

	// Table write port
	always_ff @(posedge clk) begin
		if (wr_valid && !wr_sel) begin
			sample_x[wr_idx] <= wr_coord;
		end
		if (wr_valid && wr_sel) begin
			sample_y[wr_idx] <= wr_coord;
		end
	end

	// Table read port
	always_ff @(posedge clk) begin
		rx_q <= sample_x[rd_addr_q];
		ry_q <= sample_y[rd_addr_q];
	end

	assign in_stall = (state_q != ST_IDLE) || busy;
	assign in_acc   = in_valid && !in_stall;

	// Distance to the query and best-so-far update
	assign cur_d     = (pos_q >= rx_q) ? (pos_q - rx_q) : (rx_q - pos_q);
	assign take      = (cmp_idx_s1 == '0) || (cur_d < best_d_q);
	assign nb_y      = take ? ry_q : best_y_q;
	assign scan_done = cmp_v_s1 && cmp_last_s1;
	assign out_free  = !out_valid || !out_stall;
	assign load_out  = (state_q == ST_SCAN && scan_done && out_free) ||
	                   (state_q == ST_HOLD && out_free);

	// Scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issuing_q   <= 1'b0;
			rd_addr_q   <= '0;
			cmp_v_s1    <= 1'b0;
			cmp_last_s1 <= 1'b0;
			cmp_idx_s1  <= '0;
		end else begin
			cmp_v_s1    <= issuing_q;
			cmp_last_s1 <= issuing_q && (rd_addr_q == n_eff);
			cmp_idx_s1  <= rd_addr_q;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q   <= ST_SCAN;
						issuing_q <= 1'b1;
						rd_addr_q <= '0;
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						if (rd_addr_q == n_eff) begin
							issuing_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold query and running best
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q <= position;
		end
		if (cmp_v_s1 && take) begin
			best_d_q <= cur_d;
			best_y_q <= ry_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			eased <= (state_q == ST_HOLD) ? best_y_q : nb_y;
		end
	end

	// No query taken while the table is being refilled
	a_no_query_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("query accepted during table refill");

	// A held result means the output register is occupied
	a_hold_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> out_valid)
		else $error("result held with free output register");

	// An accepted query starts a scan from entry zero
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN && issuing_q && rd_addr_q == '0))
		else $error("scan did not start after accept");

	// Reads are issued only while scanning
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> (state_q == ST_SCAN))
		else $error("table read outside of scan");

endmodule

// ----- rtl/bzlk_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: settles one quotient bit and hands the
// partial remainder, divisor and tag to the next cell.
// ----------------------------------------------------------------------------
module bzlk_div_cell #(
	parameter int RW   = 56,
	parameter int DENW = 34,
	parameter int QB   = 19,
	parameter int BIT  = 0,
	parameter int TW   = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [RW-1:0]   in_rem,
	input  logic [DENW-1:0] in_den,
	input  logic [QB-1:0]   in_quo,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [RW-1:0]   out_rem,
	output logic [DENW-1:0] out_den,
	output logic [QB-1:0]   out_quo,
	output logic [TW-1:0]   out_tag
);

	logic [RW-1:0] trial;
	logic          fits;

	// Compare remainder against the shifted divisor
	assign trial = RW'(in_den) << BIT;
	assign fits  = in_rem >= trial;

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// Subtract when it fits and set the quotient bit
	always_ff @(posedge clk) begin
		out_rem  <= fits ? (in_rem - trial) : in_rem;
		out_den  <= in_den;
		out_tag  <= in_tag;
		out_quo  <= in_quo | (fits ? (QB'(1) << BIT) : '0);
	end

endmodule

// ----- rtl/bzlk_coord.sv -----
// ----------------------------------------------------------------------------
// Curve coordinate pipeline
// Evaluates one Bezier coordinate per item as a Q16 fraction: four
// arithmetic stages build numerator and divisor, a row of divider cells
// produces the rounded quotient.
// ----------------------------------------------------------------------------
module bzlk_coord #(
	parameter int MAX_SPAN = bzlk_pkg::DEF_MAX_SPAN,
	parameter int SW       = $clog2(MAX_SPAN + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [SW-1:0]                   in_i,
	input  logic [SW-1:0]                   in_n,
	input  logic                            in_sel,
	input  logic [bzlk_pkg::CoordW-1:0]     in_c0,
	input  logic [bzlk_pkg::CoordW-1:0]     in_c1,
	output logic                            out_valid,
	output logic [SW-1:0]                   out_idx,
	output logic                            out_sel,
	output logic [bzlk_pkg::Q16W-1:0]       out_coord,
	output logic                            busy
);

	localparam int QB   = bzlk_pkg::QuotBits;
	localparam int CW   = bzlk_pkg::CoordW;
	localparam int P2   = 2 * SW;
	localparam int P3   = 3 * SW;
	localparam int TW3  = P3 + 10;
	localparam int DENW = P3 + 7;
	localparam int NW   = P3 + 12;
	localparam int RW   = NW + bzlk_pkg::FracBits + 1;
	localparam int TW   = SW + 1;

	logic [SW-1:0] u_in;

	// Stage 1: squares and cross product
	logic          v_s1;
	logic [P2-1:0] ii_s1, uu_s1, iu_s1, nn_s1;
	logic [SW-1:0] i_s1, u_s1, n_s1;
	logic [CW-1:0] c0_s1, c1_s1;
	logic [TW-1:0] tag_s1;

	// Stage 2: cubes
	logic          v_s2;
	logic [P3-1:0] a_s2, b_s2, c_s2, n3_s2;
	logic [CW-1:0] c0_s2, c1_s2;
	logic [TW-1:0] tag_s2;

	// Stage 3: weighted terms and divisor
	logic           v_s3;
	logic [TW3-1:0] t0_s3, t1_s3;
	logic [DENW-1:0] t2_s3, den_s3;
	logic [TW-1:0]  tag_s3;

	// Stage 4: dividend with rounding offset
	logic            v_s4;
	logic [RW-1:0]   dvd_s4;
	logic [DENW-1:0] den_s4;
	logic [TW-1:0]   tag_s4;

	logic [NW-1:0] num_sum;
	logic [9:0]    k0, k1;

	// Cell row links
	logic            cv   [QB+1];
	logic [RW-1:0]   crem [QB+1];
	logic [DENW-1:0] cden [QB+1];
	logic [QB-1:0]   cquo [QB+1];
	logic [TW-1:0]   ctag [QB+1];

	assign u_in = in_n - in_i;

	// Advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1
	always_ff @(posedge clk) begin
		ii_s1  <= P2'(in_i) * P2'(in_i);
		uu_s1  <= P2'(u_in) * P2'(u_in);
		iu_s1  <= P2'(in_i) * P2'(u_in);
		nn_s1  <= P2'(in_n) * P2'(in_n);
		i_s1   <= in_i;
		u_s1   <= u_in;
		n_s1   <= in_n;
		c0_s1  <= in_c0;
		c1_s1  <= in_c1;
		tag_s1 <= {in_i, in_sel};
	end

	// Stage 2
	always_ff @(posedge clk) begin
		a_s2   <= P3'(iu_s1) * P3'(u_s1);
		b_s2   <= P3'(iu_s1) * P3'(i_s1);
		c_s2   <= P3'(ii_s1) * P3'(i_s1);
		n3_s2  <= P3'(nn_s1) * P3'(n_s1);
		c0_s2  <= c0_s1;
		c1_s2  <= c1_s1;
		tag_s2 <= tag_s1;
	end

	// Stage 3
	assign k0 = 10'(c0_s2) * 10'd3;
	assign k1 = 10'(c1_s2) * 10'd3;

	always_ff @(posedge clk) begin
		t0_s3  <= TW3'(a_s2) * TW3'(k0);
		t1_s3  <= TW3'(b_s2) * TW3'(k1);
		t2_s3  <= DENW'(c_s2) * DENW'(bzlk_pkg::EndCoord);
		den_s3 <= DENW'(n3_s2) * DENW'(bzlk_pkg::EndCoord);
		tag_s3 <= tag_s2;
	end

	// Stage 4
	assign num_sum = NW'(t0_s3) + NW'(t1_s3) + NW'(t2_s3);

	always_ff @(posedge clk) begin
		dvd_s4 <= (RW'(num_sum) << bzlk_pkg::FracBits) + RW'(den_s3 >> 1);
		den_s4 <= den_s3;
		tag_s4 <= tag_s3;
	end

	// Row of divider cells, most significant quotient bit first
	assign cv[0]   = v_s4;
	assign crem[0] = dvd_s4;
	assign cden[0] = den_s4;
	assign cquo[0] = '0;
	assign ctag[0] = tag_s4;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		bzlk_div_cell #(
			.RW  (RW),
			.DENW(DENW),
			.QB  (QB),
			.BIT (QB - 1 - k),
			.TW  (TW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[k]),
			.in_rem   (crem[k]),
			.in_den   (cden[k]),
			.in_quo   (cquo[k]),
			.in_tag   (ctag[k]),
			.out_valid(cv[k+1]),
			.out_rem  (crem[k+1]),
			.out_den  (cden[k+1]),
			.out_quo  (cquo[k+1]),
			.out_tag  (ctag[k+1])
		);
	end

	// Saturate to the Q16 range
	assign out_valid = cv[QB];
	assign out_idx   = ctag[QB][TW-1:1];
	assign out_sel   = ctag[QB][0];
	assign out_coord = (cquo[QB] > QB'(bzlk_pkg::Q16Max)) ? bzlk_pkg::Q16Max
	                                                       : cquo[QB][bzlk_pkg::Q16W-1:0];

	// Any item still inside the pipeline
	always_comb begin
		busy = v_s1 | v_s2 | v_s3 | v_s4;
		for (int k = 1; k <= QB; k++) begin
			busy = busy | cv[k];
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier easing table lookup testbench
// Writes the control points and the span, predicts the sampled curve table
// and checks that each position comes back as the y of the nearest sample.
// Covers directed corners, register extremes, the unused register indexes,
// a long output hold and a random run with idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int TopSpan = bzlk_pkg::DEF_MAX_SPAN;
	localparam longint CycleLimit = 3000000;
	localparam int LongHold = 600;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bzlk_pkg::IdxW-1:0] cfg_idx;
	logic [bzlk_pkg::CfgW-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [bzlk_pkg::Q16W-1:0] position;
	logic out_valid;
	logic out_stall;
	logic [bzlk_pkg::Q16W-1:0] eased;

	// predicted register copy and sampled curve
	logic [bzlk_pkg::CoordW-1:0] p0x, p0y, p1x, p1y;
	logic [bzlk_pkg::SpanW-1:0] span_reg;
	logic [bzlk_pkg::Q16W-1:0] curve_x [0:TopSpan];
	logic [bzlk_pkg::Q16W-1:0] curve_y [0:TopSpan];

	logic [bzlk_pkg::Q16W-1:0] pending_eased [$];
	int errors;
	int checked;
	int cfg_writes;
	longint cycles;
	bit calm;
	bit hold_req;

	bezier_easing_table_lookup_unit #(.MAX_SPAN(TopSpan)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .position(position),
		.out_valid(out_valid), .out_stall(out_stall), .eased(eased)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// effective point count
	function automatic int points();
		int n;
		n = span_reg;
		if (n < bzlk_pkg::MinSpan) n = bzlk_pkg::MinSpan;
		if (n > TopSpan) n = TopSpan;
		return n;
	endfunction

	// one coordinate of sample i, rounded half up to Q16, saturated
	function automatic logic [bzlk_pkg::Q16W-1:0] bez_coord(longint c0, longint c1,
			longint i, longint n);
		longint u, num, den, q;
		u = n - i;
		num = 3 * c0 * i * u * u + 3 * c1 * u * i * i + bzlk_pkg::EndCoord * i * i * i;
		den = bzlk_pkg::EndCoord * n * n * n;
		q = (num * 65536 + den / 2) / den;
		if (q > bzlk_pkg::Q16Max) q = bzlk_pkg::Q16Max;
		return q[bzlk_pkg::Q16W-1:0];
	endfunction

	function automatic void refill_curve();
		int n;
		n = points();
		for (int i = 0; i <= n; i++) begin
			curve_x[i] = bez_coord(p0x, p1x, i, n);
			curve_y[i] = bez_coord(p0y, p1y, i, n);
		end
	endfunction

	// y of the nearest sample, lower index on a tie
	function automatic logic [bzlk_pkg::Q16W-1:0] nearest_y(logic [bzlk_pkg::Q16W-1:0] pos);
		int best, bd, d;
		best = 0;
		bd = (curve_x[0] > pos) ? curve_x[0] - pos : pos - curve_x[0];
		for (int i = 1; i <= points(); i++) begin
			d = (curve_x[i] > pos) ? curve_x[i] - pos : pos - curve_x[i];
			if (d < bd) begin
				bd = d;
				best = i;
			end
		end
		return curve_y[best];
	endfunction

	// wait for all results, then let the block settle
	task automatic drain();
		wait (pending_eased.size() == 0);
		repeat (points() + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [bzlk_pkg::IdxW-1:0] idx, logic [bzlk_pkg::CfgW-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			bzlk_pkg::REG_CTRL0_X: p0x = val[bzlk_pkg::CoordW-1:0];
			bzlk_pkg::REG_CTRL0_Y: p0y = val[bzlk_pkg::CoordW-1:0];
			bzlk_pkg::REG_CTRL1_X: p1x = val[bzlk_pkg::CoordW-1:0];
			bzlk_pkg::REG_CTRL1_Y: p1y = val[bzlk_pkg::CoordW-1:0];
			bzlk_pkg::REG_SPAN: span_reg = val;
			default: ;
		endcase
		if (idx <= bzlk_pkg::REG_SPAN) refill_curve();
		// hold until the refill finishes
		repeat (2) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_all(int c0x, int c0y, int c1x, int c1y, int sp);
		write_reg(bzlk_pkg::REG_CTRL0_X, bzlk_pkg::CfgW'(c0x));
		write_reg(bzlk_pkg::REG_CTRL0_Y, bzlk_pkg::CfgW'(c0y));
		write_reg(bzlk_pkg::REG_CTRL1_X, bzlk_pkg::CfgW'(c1x));
		write_reg(bzlk_pkg::REG_CTRL1_Y, bzlk_pkg::CfgW'(c1y));
		write_reg(bzlk_pkg::REG_SPAN, bzlk_pkg::CfgW'(sp));
	endtask

	// offer one item, keep valid high afterward
	task automatic send_position(logic [bzlk_pkg::Q16W-1:0] pos);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		position <= pos;
		do @(posedge clk); while (in_stall);
		pending_eased.insert(pending_eased.size(), nearest_y(pos));
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random position: mostly inside the unit range, some near samples
	function automatic logic [bzlk_pkg::Q16W-1:0] pick_position();
		int k;
		case ($urandom_range(0, 3))
			0: return bzlk_pkg::Q16W'($urandom_range(0, 131071));
			1: begin
				k = $urandom_range(0, points());
				return bzlk_pkg::Q16W'(curve_x[k] + $urandom_range(0, 6) - 3);
			end
			default: return bzlk_pkg::Q16W'($urandom_range(0, 65536));
		endcase
	endfunction

	// output stall: random bursts, or a long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_eased.size() == 0) begin
				$display("%0t: unexpected result eased=%0d", $time, eased);
				errors++;
			end else begin
				if (eased !== pending_eased[0]) begin
					$display("%0t: eased mismatch expected %0d actual %0d", $time,
						pending_eased[0], eased);
					errors++;
				end
				void'(pending_eased.pop_front());
				checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic test_directed();
		int k;
		write_all(bzlk_pkg::RST_CTRL0, bzlk_pkg::RST_CTRL0, bzlk_pkg::RST_CTRL1,
			bzlk_pkg::RST_CTRL1, bzlk_pkg::RST_SPAN);
		send_position(0);
		send_position(131071);
		send_position(65536);
		send_position(32768);
		send_position(65535);
		for (int i = 0; i < 6; i++) send_position(curve_x[$urandom_range(0, points())]);
		// ties between neighbors
		for (int i = 0; i < 8; i++) begin
			k = $urandom_range(0, points() - 1);
			send_position((curve_x[k] + curve_x[k + 1]) >> 1);
		end
		end_burst();
	endtask

	task automatic test_extremes();
		int sets [5][5] = '{
			'{0, 0, 0, 0, 0}, '{255, 255, 255, 255, 256},
			'{511, 511, 511, 511, 511}, '{127, 0, 0, 127, 15},
			'{0, 255, 255, 0, 257}};
		foreach (sets[s]) begin
			write_all(sets[s][0], sets[s][1], sets[s][2], sets[s][3], sets[s][4]);
			send_position(0);
			send_position(131071);
			for (int i = 0; i < 10; i++) send_position(pick_position());
			end_burst();
		end
	endtask

	task automatic test_unused_regs();
		write_all(40, 10, 90, 120, 33);
		for (int idx = bzlk_pkg::REG_SPAN + 1; idx < (1 << bzlk_pkg::IdxW); idx++)
			write_reg(bzlk_pkg::IdxW'(idx), bzlk_pkg::CfgW'($urandom_range(0, 511)));
		for (int i = 0; i < 10; i++) send_position(pick_position());
		end_burst();
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++) send_position(pick_position());
		end_burst();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 14; ph++) begin
			if (ph == 11) calm = 1'b1;
			write_all($urandom_range(0, 511), $urandom_range(0, 511),
				$urandom_range(0, 511), $urandom_range(0, 511),
				(ph % 4 == 0) ? $urandom_range(0, 511) : $urandom_range(0, 40));
			repeat (60) send_position(pick_position());
			end_burst();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		position = '0;
		errors = 0;
		checked = 0;
		cfg_writes = 0;
		cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		p0x = bzlk_pkg::RST_CTRL0;
		p0y = bzlk_pkg::RST_CTRL0;
		p1x = bzlk_pkg::RST_CTRL1;
		p1y = bzlk_pkg::RST_CTRL1;
		span_reg = bzlk_pkg::RST_SPAN;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extremes();
		test_unused_regs();
		test_backpressure();
		test_random();
		drain();
		$display("checked %0d lookups over %0d register writes", checked, cfg_writes);
		$display("spans 0..511, control points 0..511, long output hold included");
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule
